// ===== rtl/text_console_writer_macros.svh =====
// assertion macros shared by the console writer rtl
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// types and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // character and attribute constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/tcw_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/text_console_writer.sv =====
// text console writer: cell store, cursor and scroll/clear sequencer
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

// Text console of ROWS x COLUMNS cells (attribute high byte, character low byte)
// held in one RAM with a registered read port. After reset the block runs a
// clearing pass over all ROWS*COLUMNS cells and takes no request until it ends;
// attribute writes are taken at any time. One request is handled at a time. A
// put or newline that runs off the bottom row scrolls, moving each cell up one
// row with a read and then a write through the single RAM port, then blanking
// the last row. The cell address comes from one shared row*COLUMNS+column unit;
// the sweeps are driven by one cell counter. A finished result sits in an output
// register, so the next request is taken while it waits.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcw_pkg::OP_W-1:0]      i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::POS_W-1:0]     i_row,
    input  logic [tcw_pkg::POS_W-1:0]     i_column,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcw_pkg::CUR_ROW_W-1:0] o_cursor_row,
    output logic [tcw_pkg::CUR_COL_W-1:0] o_cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    // attribute register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_attribute
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_MOVE   = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    // state and registers
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ATTR_W-1:0]   r_attribute;
    logic [OP_W-1:0]     r_op, n_op;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [ROW_W-1:0]    r_arow, n_arow;
    logic [COL_W-1:0]    r_acol, n_acol;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic                r_out_valid, n_out_valid;
    logic [CUR_ROW_W-1:0] r_cursor_row, n_cursor_row;
    logic [CUR_COL_W-1:0] r_cursor_col, n_cursor_col;
    logic [CELL_W-1:0]   r_cell_data, n_cell_data;

    // request clamping
    logic [POS_W-1:0]    clamp_row;
    logic [POS_W:0]      clamp_col;

    // shared address unit
    logic [ROW_W-1:0]    m_row;
    logic [COL_W-1:0]    m_col;
    logic [31:0]         m_addr_full;
    logic [ADDR_W-1:0]   m_addr;

    // ram ports
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [CELL_W-1:0]   ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [CELL_W-1:0]   ram_rd_data;

    // output widening
    logic [31:0]         row_ext;
    logic [31:0]         col_ext;

    logic                in_fire;
    logic                out_fire;
    logic                out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // clamp row and column of a request
    always_comb begin
        clamp_row = (i_row >= POS_W'(ROWS)) ? POS_W'(ROWS - 1) : i_row;
        clamp_col = ({1'b0, i_column} >= (POS_W + 1)'(COLUMNS)) ?
                    (POS_W + 1)'(COLUMNS - 1) : {1'b0, i_column};
    end

    // shared row*COLUMNS+column address unit
    always_comb begin
        m_row       = (r_op == OP_READ) ? r_arow : r_row;
        m_col       = (r_op == OP_READ) ? r_acol : r_col;
        m_addr_full = 32'(m_row) * 32'(COLUMNS) + 32'(m_col);
        m_addr      = m_addr_full[ADDR_W-1:0];
    end

    // ram port selection
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = {r_attribute, BLANK_CHAR};
        ram_rd_addr = m_addr;
        case (r_state)
            ST_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {RESET_ATTR, BLANK_CHAR};
            end
            ST_EXEC: begin
                ram_wr_en   = (r_op == OP_PUT) && (r_char != NEWLINE_CODE);
                ram_wr_addr = m_addr;
                ram_wr_data = {r_attribute, r_char};
            end
            ST_SCROLL_RD: begin
                ram_rd_addr = r_idx + ROW_STRIDE;
            end
            ST_SCROLL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
            end
            ST_FILL: begin
                ram_wr_en   = 1'b1;
            end
            default: begin
                ram_wr_en   = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // result widening to port widths
    always_comb begin
        row_ext = 32'(r_row);
        col_ext = 32'(r_col);
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_row        = r_row;
        n_col        = r_col;
        n_op         = r_op;
        n_char       = r_char;
        n_arow       = r_arow;
        n_acol       = r_acol;
        n_cell       = r_cell;
        n_out_valid  = out_fire ? 1'b0 : r_out_valid;
        n_cursor_row = r_cursor_row;
        n_cursor_col = r_cursor_col;
        n_cell_data  = r_cell_data;
        o_in_ready   = 1'b0;

        case (r_state)
            // clearing pass after reset
            ST_INIT: begin
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // take a request
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_char  = i_char_code;
                    n_arow  = clamp_row[ROW_W-1:0];
                    n_acol  = clamp_col[COL_W-1:0];
                    n_cell  = '0;
                    n_state = ST_EXEC;
                end
            end
            // act on the request
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_op)
                    OP_PUT: begin
                        if ((r_char == NEWLINE_CODE) || (r_col == LAST_COL)) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                n_idx   = '0;
                                n_state = ST_SCROLL_RD;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                    OP_SET: begin
                        n_row = r_arow;
                        n_col = r_acol;
                    end
                    OP_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_idx   = '0;
                        n_state = ST_FILL;
                    end
                    default: begin
                        n_state = ST_READ_WAIT;
                    end
                endcase
            end
            // capture the cell read
            ST_READ_WAIT: begin
                n_cell  = ram_rd_data;
                n_state = ST_DONE;
            end
            // scroll: fetch the cell one row below
            ST_SCROLL_RD: begin
                n_state = ST_SCROLL_WR;
            end
            // scroll: store it one row up
            ST_SCROLL_WR: begin
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == LAST_MOVE) ? ST_FILL : ST_SCROLL_RD;
            end
            // blank cells up to the end of the store
            ST_FILL: begin
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_cursor_row = row_ext[CUR_ROW_W-1:0];
                    n_cursor_col = col_ext[CUR_COL_W-1:0];
                    n_cell_data  = r_cell;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attribute <= RESET_ATTR;
        end else if (i_cfg_valid) begin
            r_attribute <= i_cfg_attribute;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_char       <= n_char;
        r_arow       <= n_arow;
        r_acol       <= n_acol;
        r_cell       <= n_cell;
        r_cursor_row <= n_cursor_row;
        r_cursor_col <= n_cursor_col;
        r_cell_data  <= n_cell_data;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_cursor_row    = r_cursor_row;
    assign o_cursor_column = r_cursor_col;
    assign o_cell_data     = r_cell_data;

    // checks
    `TCW_ASSERT_NEXT(a_one_request, in_fire, !o_in_ready, "second request taken while busy")
    `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (r_row <= LAST_ROW) && (r_col <= LAST_COL), "cursor out of range")
    `TCW_ASSERT_NOW(a_write_range, ram_wr_en, ram_wr_addr <= LAST_CELL, "cell write beyond store")
    `TCW_ASSERT_NEXT(a_result_loaded, (r_state == ST_DONE) && out_free, r_out_valid && o_in_ready, "result not presented")

endmodule

// ===== dv/text_console_writer_tb.sv =====
// self-checking testbench for the text console writer
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS       = 80;
    localparam int ROWS_N     = 25;
    localparam int CELL_COUNT = COLS * ROWS_N;
    localparam int QUIET_LIMIT = 40000;
    localparam int PHASE_ITEMS = 400;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_console_req;

    typedef struct packed {
        logic [CUR_ROW_W-1:0] row;
        logic [CUR_COL_W-1:0] col;
        logic [CELL_W-1:0]    data;
    } t_console_res;

    typedef struct packed {
        t_console_req rq;
        logic         typed;
        t_console_res want;
    } t_directed_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op            = OP_PUT;
    logic [CHAR_W-1:0]    i_char_code     = '0;
    logic [POS_W-1:0]     i_row           = '0;
    logic [POS_W-1:0]     i_column        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [CUR_ROW_W-1:0] o_cursor_row;
    logic [CUR_COL_W-1:0] o_cursor_column;
    logic [CELL_W-1:0]    o_cell_data;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [ATTR_W-1:0]    i_cfg_attribute = '0;

    // shadow copy of the console: cells, cursor and attribute
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int unsigned       cursor_idx = 0;
    logic [ATTR_W-1:0] attr_now   = RESET_ATTR;

    t_console_res  awaited_results [$];
    t_directed_row directed_rows [$];
    int unsigned   mismatches  = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   idle_pct    = 0;
    int unsigned   stall_pct   = 0;
    // caps on the slow requests so the run stays short
    int unsigned   scrolls_left = 80;
    int unsigned   clears_left  = 30;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS_N)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_row          (i_row),
        .i_column       (i_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_column(o_cursor_column),
        .o_cell_data    (o_cell_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_attribute(i_cfg_attribute)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // row and column clamped to the screen, as a linear index
    function automatic int unsigned clamped_cell(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
        int unsigned rr;
        int unsigned cc;
        rr = (r >= ROWS_N) ? ROWS_N - 1 : r;
        cc = (c >= COLS) ? COLS - 1 : c;
        return rr * COLS + cc;
    endfunction

    // apply one request to the shadow console and return the cursor/cell it reports
    function automatic t_console_res apply_console_op(t_console_req rq);
        t_console_res rs;
        int unsigned  i;
        rs = '0;
        case (rq.op)
            OP_PUT: begin
                if (rq.ch == NEWLINE_CODE) begin
                    cursor_idx += COLS - cursor_idx % COLS;
                end else begin
                    cells[cursor_idx] = {attr_now, rq.ch};
                    cursor_idx++;
                end
                // ran off the last cell: move rows up, blank the bottom row
                if (cursor_idx >= CELL_COUNT) begin
                    for (i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
                    for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                        cells[i] = {attr_now, BLANK_CHAR};
                    cursor_idx = (ROWS_N - 1) * COLS;
                end
            end
            OP_SET: begin
                cursor_idx = clamped_cell(rq.row, rq.col);
            end
            OP_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++) cells[i] = {attr_now, BLANK_CHAR};
                cursor_idx = 0;
            end
            default: begin
                rs.data = cells[clamped_cell(rq.row, rq.col)];
            end
        endcase
        rs.row = CUR_ROW_W'(cursor_idx / COLS);
        rs.col = CUR_COL_W'(cursor_idx % COLS);
        return rs;
    endfunction

    // random request, biased toward the bottom rows and row ends so scrolls happen
    function automatic t_console_req next_random_request();
        t_console_req rq;
        int unsigned  pick;
        int unsigned  nxt;
        pick = $urandom_range(99);
        rq.ch = ($urandom_range(99) < 12) ? NEWLINE_CODE : CHAR_W'($urandom_range(255));
        case ($urandom_range(4))
            0, 1:    rq.row = POS_W'($urandom_range(ROWS_N - 1, ROWS_N - 3));
            2, 3:    rq.row = POS_W'($urandom_range(ROWS_N - 1));
            default: rq.row = POS_W'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0, 1, 2: rq.col = POS_W'($urandom_range(COLS - 1, COLS - 10));
            8, 9:    rq.col = POS_W'($urandom_range(255));
            default: rq.col = POS_W'($urandom_range(COLS - 1));
        endcase
        if (pick < 50) rq.op = OP_PUT;
        else if (pick < 68) rq.op = OP_SET;
        else if (pick < 98) rq.op = OP_READ;
        else rq.op = OP_CLEAR;
        if (rq.op == OP_PUT) begin
            nxt = (rq.ch == NEWLINE_CODE) ? cursor_idx + COLS - cursor_idx % COLS
                                          : cursor_idx + 1;
            if (nxt >= CELL_COUNT) begin
                if (scrolls_left == 0) rq.op = OP_SET;
                else scrolls_left--;
            end
        end else if (rq.op == OP_CLEAR) begin
            if (clears_left == 0) rq.op = OP_READ;
            else clears_left--;
        end
        return rq;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, logic [7:0] ch, logic [7:0] r, logic [7:0] c,
                           logic typed, int er, int ec, logic [15:0] ed);
        t_directed_row d;
        d.rq    = '{op: op, ch: ch, row: r, col: c};
        d.typed = typed;
        d.want  = '{row: CUR_ROW_W'(er), col: CUR_COL_W'(ec), data: ed};
        directed_rows.push_back(d);
    endtask

    // present one request, with random sender gaps, and record what it should return
    task automatic send_request(t_console_req rq, logic typed, t_console_res want);
        t_console_res predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= rq.op;
        i_char_code <= rq.ch;
        i_row       <= rq.row;
        i_column    <= rq.col;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_console_op(rq);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // attribute write, only while the console is idle
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        i_cfg_valid     <= 1'b1;
        i_cfg_attribute <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        attr_now = value;
        i_cfg_valid <= 1'b0;
    endtask

    // result ready with random stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checking and watchdog
    always @(posedge i_clk) begin : result_check
        t_console_res got;
        t_console_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{row: o_cursor_row, col: o_cursor_column, data: o_cell_data};
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: row %0d col %0d cell %h",
                           got.row, got.col, got.data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.row !== want.row) begin
                        $error("cursor_row: expected %0d, got %0d", want.row, got.row);
                        mismatches++;
                    end
                    if (got.col !== want.col) begin
                        $error("cursor_column: expected %0d, got %0d", want.col, got.col);
                        mismatches++;
                    end
                    if (got.data !== want.data) begin
                        $error("cell_data: expected %h, got %h", want.data, got.data);
                        mismatches++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned  sender_idle [4];
        int unsigned  recv_stall [4];
        logic [ATTR_W-1:0] attr_pick;
        int unsigned  ph;
        int unsigned  n;
        int unsigned  i;
        sender_idle = '{0, 77, 0, 29};
        recv_stall  = '{0, 0, 77, 29};
        for (i = 0; i < CELL_COUNT; i++) cells[i] = {RESET_ATTR, BLANK_CHAR};

        // directed part, reset attribute
        add_row(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  0,  16'h0F20);
        add_row(OP_READ,  8'h00, 8'd255, 8'd255, 1, 0,  0,  16'h0F20);
        add_row(OP_PUT,   8'h41, 8'd255, 8'd255, 1, 0,  1,  16'h0000);
        add_row(OP_PUT,   8'h00, 8'd0,   8'd0,   1, 0,  2,  16'h0000);
        add_row(OP_PUT,   8'hFF, 8'd0,   8'd0,   1, 0,  3,  16'h0000);
        add_row(OP_READ,  8'h00, 8'd0,   8'd0,   1, 0,  3,  16'h0F41);
        add_row(OP_READ,  8'h00, 8'd0,   8'd1,   1, 0,  3,  16'h0F00);
        add_row(OP_READ,  8'h00, 8'd0,   8'd2,   1, 0,  3,  16'h0FFF);
        add_row(OP_PUT,   NEWLINE_CODE, 8'd0, 8'd0, 1, 1, 0, 16'h0000);
        add_row(OP_SET,   8'h00, 8'd200, 8'd200, 1, 24, 79, 16'h0000);
        // last cell written, so everything scrolls
        add_row(OP_PUT,   8'h5A, 8'd0,   8'd0,   1, 24, 0,  16'h0000);
        add_row(OP_READ,  8'h00, 8'd23,  8'd79,  1, 24, 0,  16'h0F5A);
        add_row(OP_READ,  8'h00, 8'd24,  8'd0,   1, 24, 0,  16'h0F20);
        add_row(OP_SET,   8'hFF, 8'd24,  8'd5,   1, 24, 5,  16'h0000);
        // newline on the bottom row scrolls too
        add_row(OP_PUT,   NEWLINE_CODE, 8'd0, 8'd0, 1, 24, 0, 16'h0000);
        add_row(OP_READ,  8'h00, 8'd22,  8'd79,  1, 24, 0,  16'h0F5A);
        add_row(OP_CLEAR, 8'hFF, 8'd255, 8'd255, 1, 0,  0,  16'h0000);
        add_row(OP_READ,  8'h00, 8'd22,  8'd79,  1, 0,  0,  16'h0F20);
        add_row(OP_SET,   8'h00, 8'd0,   8'd79,  1, 0,  79, 16'h0000);
        add_row(OP_PUT,   8'h78, 8'd0,   8'd0,   1, 1,  0,  16'h0000);
        add_row(OP_READ,  NEWLINE_CODE, 8'd0, 8'd79, 1, 1, 0, 16'h0F78);
        add_row(OP_PUT,   NEWLINE_CODE, 8'd0, 8'd0, 1, 2, 0, 16'h0000);
        add_row(OP_SET,   8'h00, 8'd24,  8'd78,  0, 0,  0,  16'h0000);
        add_row(OP_PUT,   8'h0B, 8'd0,   8'd0,   0, 0,  0,  16'h0000);
        add_row(OP_PUT,   8'h09, 8'd0,   8'd0,   0, 0,  0,  16'h0000);

        // synchronous reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
        end

        // random phases, each with its own attribute and idling pattern
        for (ph = 0; ph < 4; ph++) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            wait_drained();
            idle_pct  = sender_idle[ph];
            stall_pct = recv_stall[ph];
            if (ph == 0) attr_pick = 8'h00;
            else if (ph == 1) attr_pick = 8'hFF;
            else attr_pick = ATTR_W'($urandom_range(255));
            write_attribute(attr_pick);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // now and then hold off until the console has answered everything
                if ($urandom_range(99) == 0) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    wait_drained();
                end
                send_request(next_random_request(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
